/* sv/wcs_pkg.sv */
package wcs_pkg;

	// Widths of the ambient sample and of the seconds counter
	localparam int SAMPLE_BITS  = 10;
	localparam int SECONDS_BITS = 16;

	// Width of the ambient value in tenths of a degree, and the scale to it
	localparam int TENTHS_BITS = 9;
	localparam logic [TENTHS_BITS-1:0] FULL_SCALE_TENTHS = 9'd500;

	// Configuration register indexes
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_SECOND   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WASH_SECONDS       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_DRAIN_SECONDS      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPIN_SECONDS       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ABORT_PUMP_SECONDS = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOT_LIMIT          = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_COOL_LIMIT         = 3'd6;

	// Configuration reset values
	localparam logic [7:0]  RST_TICKS_PER_SECOND   = 8'd183;
	localparam logic [15:0] RST_WASH_SECONDS       = 16'd30;
	localparam logic [15:0] RST_DRAIN_SECONDS      = 16'd10;
	localparam logic [15:0] RST_SPIN_SECONDS       = 16'd20;
	localparam logic [15:0] RST_ABORT_PUMP_SECONDS = 16'd10;
	localparam logic [8:0]  RST_HOT_LIMIT          = 9'd300;
	localparam logic [8:0]  RST_COOL_LIMIT         = 9'd270;

	// Port byte values
	localparam logic [7:0] P0_OFF    = 8'h00;
	localparam logic [7:0] P0_MOTOR  = 8'h08;
	localparam logic [7:0] P0_SPIN   = 8'h18;
	localparam logic [7:0] P1_OFF    = 8'h00;
	localparam logic [7:0] P1_VALVE  = 8'h04;
	localparam logic [7:0] P1_HEATER = 8'h08;
	localparam logic [7:0] P1_PUMP   = 8'h10;

	// Request kinds
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CONTROL = 2'd1,
		OP_ABORT   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// One input request
	typedef struct packed {
		logic [1:0]             op;
		logic                   main_switch;
		logic                   select_hot;
		logic                   level_reached;
		logic                   reached_hot;
		logic                   reached_warm;
		logic [SAMPLE_BITS-1:0] ambient_sample;
	} item_t;

	// Configuration register contents
	typedef struct packed {
		logic [7:0]  ticks_per_second;
		logic [15:0] wash_seconds;
		logic [15:0] drain_seconds;
		logic [15:0] spin_seconds;
		logic [15:0] abort_pump_seconds;
		logic [8:0]  hot_limit;
		logic [8:0]  cool_limit;
	} cfg_t;

	// One result
	typedef struct packed {
		logic [3:0]  phase;
		logic [7:0]  port0_drive;
		logic [7:0]  port1_drive;
		logic        run_enabled;
		logic [15:0] seconds_elapsed;
		logic        abort_waiting;
	} status_t;

endpackage

/* sv/wash_cycle_sequencer_core.sv */
// Wash cycle sequencer: every accepted request (timer tick, control pass or
// switch-off event) gives exactly one result holding the phase, both port
// bytes, the run flag, the seconds counter and the pending abort flag as they
// stand after that request. One request is taken every clock cycle unless
// in_stall is high; a request enters an input register, its state update is
// one short step of logic, and its result is loaded into the output register.
// A stalled output holds its result while one more request waits in the input
// register. Configuration writes take effect at once and are meant to happen
// while no request is in flight.
module wash_cycle_sequencer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              wr_en,
	input  logic [wcs_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [wcs_pkg::CFG_DATA_BITS-1:0] wr_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic                              main_switch,
	input  logic                              select_hot,
	input  logic                              level_reached,
	input  logic                              reached_hot,
	input  logic                              reached_warm,
	input  logic [wcs_pkg::SAMPLE_BITS-1:0]   ambient_sample,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        phase,
	output logic [7:0]                        port0_drive,
	output logic [7:0]                        port1_drive,
	output logic                              run_enabled,
	output logic [15:0]                       seconds_elapsed,
	output logic                              abort_waiting
);

	wcs_pkg::cfg_t    cfg;
	wcs_pkg::item_t   item_s1;
	wcs_pkg::status_t nxt;
	wcs_pkg::status_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;

	wcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Step the request in the input register when the result slot is free
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	wcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.nxt     (nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op             <= op;
			item_s1.main_switch    <= main_switch;
			item_s1.select_hot     <= select_hot;
			item_s1.level_reached  <= level_reached;
			item_s1.reached_hot    <= reached_hot;
			item_s1.reached_warm   <= reached_warm;
			item_s1.ambient_sample <= ambient_sample;
		end
	end

	// Result register: load on advance, hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= nxt;
	end

	assign out_valid       = out_valid_q;
	assign phase           = res_q.phase;
	assign port0_drive     = res_q.port0_drive;
	assign port1_drive     = res_q.port1_drive;
	assign run_enabled     = res_q.run_enabled;
	assign seconds_elapsed = res_q.seconds_elapsed;
	assign abort_waiting   = res_q.abort_waiting;

endmodule

/* sv/wcs_cfg_regs.sv */
module wcs_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [wcs_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [wcs_pkg::CFG_DATA_BITS-1:0] wr_data,
	output wcs_pkg::cfg_t                     cfg
);

	wcs_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second   <= wcs_pkg::RST_TICKS_PER_SECOND;
			cfg_q.wash_seconds       <= wcs_pkg::RST_WASH_SECONDS;
			cfg_q.drain_seconds      <= wcs_pkg::RST_DRAIN_SECONDS;
			cfg_q.spin_seconds       <= wcs_pkg::RST_SPIN_SECONDS;
			cfg_q.abort_pump_seconds <= wcs_pkg::RST_ABORT_PUMP_SECONDS;
			cfg_q.hot_limit          <= wcs_pkg::RST_HOT_LIMIT;
			cfg_q.cool_limit         <= wcs_pkg::RST_COOL_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				wcs_pkg::REG_TICKS_PER_SECOND:   cfg_q.ticks_per_second   <= wr_data[7:0];
				wcs_pkg::REG_WASH_SECONDS:       cfg_q.wash_seconds       <= wr_data[15:0];
				wcs_pkg::REG_DRAIN_SECONDS:      cfg_q.drain_seconds      <= wr_data[15:0];
				wcs_pkg::REG_SPIN_SECONDS:       cfg_q.spin_seconds       <= wr_data[15:0];
				wcs_pkg::REG_ABORT_PUMP_SECONDS: cfg_q.abort_pump_seconds <= wr_data[15:0];
				wcs_pkg::REG_HOT_LIMIT:          cfg_q.hot_limit          <= wr_data[8:0];
				wcs_pkg::REG_COOL_LIMIT:         cfg_q.cool_limit         <= wr_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/wcs_ctrl.sv */
module wcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  wcs_pkg::item_t   item,
	input  wcs_pkg::cfg_t    cfg,
	output wcs_pkg::status_t nxt
);

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_FILL       = 4'd1,
		PH_PREHEAT    = 4'd2,
		PH_WASH       = 4'd3,
		PH_DRAIN      = 4'd4,
		PH_SPIN       = 4'd5,
		PH_STOP       = 4'd6,
		PH_ABORT      = 4'd7,
		PH_ABORT_PUMP = 4'd8,
		PH_DONE       = 4'd9
	} phase_t;

	localparam int PROD_BITS = wcs_pkg::SAMPLE_BITS + wcs_pkg::TENTHS_BITS;

	phase_t                            ph_q, ph_d, ph_cur;
	logic [7:0]                        sub_q, sub_d, sub_inc;
	logic [wcs_pkg::SECONDS_BITS-1:0]  sec_q, sec_d;
	logic                              run_q, run_d;
	logic                              abt_q, abt_d;
	logic [7:0]                        p0_q, p0_d;
	logic [7:0]                        p1_q, p1_d;
	logic [PROD_BITS-1:0]              product;
	logic [wcs_pkg::TENTHS_BITS-1:0]   tenths;
	logic [31:0]                       sec_ext;
	logic                              target;

	// Scale the sample to tenths of a degree
	assign product = PROD_BITS'(item.ambient_sample) * PROD_BITS'(wcs_pkg::FULL_SCALE_TENTHS);
	assign tenths  = product[PROD_BITS-1:wcs_pkg::SAMPLE_BITS];
	assign sec_ext = 32'(sec_q);
	assign sub_inc = sub_q + 8'd1;
	assign target  = item.select_hot ? item.reached_hot : item.reached_warm;

	// Next state for the request in hand
	always_comb begin
		ph_d   = ph_q;
		ph_cur = ph_q;
		sub_d  = sub_q;
		sec_d  = sec_q;
		run_d  = run_q;
		abt_d  = abt_q;
		p0_d   = p0_q;
		p1_d   = p1_q;
		if (step_en) begin
			case (wcs_pkg::op_t'(item.op))
				wcs_pkg::OP_TICK: begin
					if (sub_inc >= cfg.ticks_per_second) begin
						sub_d = 8'd0;
						sec_d = sec_q + {{(wcs_pkg::SECONDS_BITS-1){1'b0}}, 1'b1};
					end else begin
						sub_d = sub_inc;
					end
				end
				wcs_pkg::OP_CONTROL: begin
					// Run/stop hysteresis on the ambient value
					if (run_q) begin
						if (tenths >= cfg.hot_limit)
							run_d = 1'b0;
					end else if (tenths <= cfg.cool_limit) begin
						run_d = 1'b1;
					end
					if (run_d) begin
						// Handle a pending abort first
						if (abt_q) begin
							if (ph_q != PH_IDLE && ph_q != PH_DONE)
								ph_cur = PH_ABORT;
							abt_d = 1'b0;
						end
						ph_d = ph_cur;
						unique case (ph_cur)
							PH_IDLE: begin
								if (item.main_switch)
									ph_d = PH_FILL;
							end
							PH_FILL: begin
								if (item.level_reached) begin
									p1_d  = wcs_pkg::P1_OFF;
									ph_d  = PH_PREHEAT;
									sec_d = '0;
								end else begin
									p1_d = wcs_pkg::P1_VALVE;
								end
							end
							PH_PREHEAT: begin
								if (!target) begin
									p1_d = wcs_pkg::P1_HEATER;
								end else begin
									ph_d  = PH_WASH;
									sec_d = '0;
								end
							end
							PH_WASH: begin
								if (sec_ext >= 32'(cfg.wash_seconds)) begin
									ph_d  = PH_DRAIN;
									sec_d = '0;
								end else begin
									p1_d = target ? wcs_pkg::P1_OFF : wcs_pkg::P1_HEATER;
								end
								p0_d = wcs_pkg::P0_MOTOR;
							end
							PH_DRAIN: begin
								if (sec_ext >= 32'(cfg.drain_seconds)) begin
									ph_d  = PH_SPIN;
									sec_d = '0;
								end else begin
									p0_d = wcs_pkg::P0_SPIN;
									p1_d = wcs_pkg::P1_PUMP;
								end
							end
							PH_SPIN: begin
								if (sec_ext >= 32'(cfg.spin_seconds)) begin
									ph_d = PH_STOP;
								end else begin
									p0_d = wcs_pkg::P0_SPIN;
									p1_d = wcs_pkg::P1_OFF;
								end
							end
							PH_STOP: begin
								p0_d = wcs_pkg::P0_OFF;
								ph_d = PH_DONE;
							end
							PH_ABORT: begin
								p0_d  = wcs_pkg::P0_OFF;
								p1_d  = wcs_pkg::P1_PUMP;
								ph_d  = PH_ABORT_PUMP;
								sec_d = '0;
							end
							PH_ABORT_PUMP: begin
								if (sec_ext >= 32'(cfg.abort_pump_seconds)) begin
									p1_d = wcs_pkg::P1_OFF;
									ph_d = PH_DONE;
								end
							end
							PH_DONE: begin
								if (!item.main_switch)
									ph_d = PH_IDLE;
							end
							default: ;
						endcase
					end
				end
				wcs_pkg::OP_ABORT: abt_d = 1'b1;
				default: ;
			endcase
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			sub_q <= 8'd0;
			sec_q <= '0;
			run_q <= 1'b1;
			abt_q <= 1'b0;
			p0_q  <= wcs_pkg::P0_OFF;
			p1_q  <= wcs_pkg::P1_OFF;
		end else begin
			ph_q  <= ph_d;
			sub_q <= sub_d;
			sec_q <= sec_d;
			run_q <= run_d;
			abt_q <= abt_d;
			p0_q  <= p0_d;
			p1_q  <= p1_d;
		end
	end

	// Present the state after this request
	assign nxt.phase           = ph_d;
	assign nxt.port0_drive     = p0_d;
	assign nxt.port1_drive     = p1_d;
	assign nxt.run_enabled     = run_d;
	assign nxt.seconds_elapsed = 16'(sec_d);
	assign nxt.abort_waiting   = abt_d;

endmodule
